// File: rtl/core/assert_macros.svh
// assertion macros shared by the ray box core modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/core/rbfi_pkg.sv
// shared types, widths, codes and helpers for the ray box face intersect core
`default_nettype none

package rbfi_pkg;

  localparam int COORD_W   = 32;
  localparam int FRAC_BITS = 16;
  localparam int DIR_W     = FRAC_BITS + 2;
  localparam int EDGE_W    = COORD_W - 1;
  localparam int O2_W      = COORD_W + 1;
  localparam int CALC_W    = COORD_W + 3;
  localparam int NUM_MW    = COORD_W + 2;
  localparam int PROD_W    = NUM_MW + DIR_W;
  localparam int PT_W      = PROD_W + 2;
  localparam int DIFF_W    = PT_W + 1;
  localparam int CNT_W     = $clog2(PROD_W);
  localparam int DATA_W    = (COORD_W > 32) ? 64 : 32;
  localparam int REG_SHIFT = (COORD_W > 32) ? 3 : 2;
  localparam int ADDR_W    = REG_SHIFT + 2;

  localparam logic [EDGE_W-1:0] EDGE_RESET = EDGE_W'(65536);

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic [1:0] {
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_CENTER_Z,
    REG_EDGE
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLASS,
    S_FACE,
    S_NUM,
    S_MD_START,
    S_MD_WAIT,
    S_CHECK,
    S_DONE
  } rbfi_state_t;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_state_t;

  typedef struct packed {
    logic              start;
    logic [NUM_MW-1:0] a;
    logic [DIR_W-1:0]  b;
    logic [DIR_W-1:0]  d;
  } md_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } md_stat_t;

  // floor half of a doubled-scale value, saturated to a coordinate
  function automatic logic signed [COORD_W-1:0] half_sat(input logic signed [PT_W-1:0] v);
    logic [PT_W-2:0]         h;
    logic [PT_W-COORD_W-1:0] hi;
    h  = v[PT_W-1:1];
    hi = h[PT_W-2:COORD_W-1];
    if (!h[PT_W-2] && (|hi)) begin
      half_sat = {1'b0, {(COORD_W-1){1'b1}}};
    end else if (h[PT_W-2] && !(&hi)) begin
      half_sat = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      half_sat = h[COORD_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/rbfi_muldiv.sv
// shared multiply then bit-serial restoring divide: trunc(a * b / d)
`default_nettype none

`include "assert_macros.svh"

module rbfi_muldiv (
  input  logic                         clk,
  input  logic                         rst,
  input  rbfi_pkg::md_req_t            req,
  output rbfi_pkg::md_stat_t           stat,
  output logic [rbfi_pkg::PROD_W-1:0]  q
);
  import rbfi_pkg::*;

  md_state_t         state;
  md_state_t         state_next;
  logic [NUM_MW-1:0] a_r;
  logic [DIR_W-1:0]  b_r;
  logic [DIR_W-1:0]  d_r;
  logic [PROD_W-1:0] dq;
  logic [DIR_W-1:0]  rem;
  logic [CNT_W-1:0]  count;
  logic              done_r;
  logic [DIR_W:0]    rem_sh;
  logic [DIR_W:0]    rem_sub;
  logic              fits;

  assign rem_sh  = {rem, dq[PROD_W-1]};
  assign fits    = rem_sh >= {1'b0, d_r};
  assign rem_sub = rem_sh - {1'b0, d_r};

  assign stat = '{busy: state != MD_IDLE, done: done_r};
  assign q    = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MD_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      MD_IDLE: begin
        if (req.start) state_next = MD_MUL;
      end
      MD_MUL: state_next = MD_DIV;
      MD_DIV: begin
        if (count == '0) state_next = MD_IDLE;
      end
      default: state_next = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done_r <= 1'b0;
    end else begin
      done_r <= (state == MD_DIV) && (count == '0);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      MD_IDLE: begin
        if (req.start) begin
          a_r <= req.a;
          b_r <= req.b;
          d_r <= req.d;
          rem <= '0;
        end
      end
      MD_MUL: begin
        dq    <= PROD_W'(a_r) * PROD_W'(b_r);
        count <= CNT_W'(PROD_W - 1);
      end
      MD_DIV: begin
        rem   <= fits ? rem_sub[DIR_W-1:0] : rem_sh[DIR_W-1:0];
        dq    <= {dq[PROD_W-2:0], fits};
        count <= count - 1'b1;
      end
      default: ;
    endcase
  end

  `ASSERT_NXT(a_start_to_mul, clk, rst, state == MD_IDLE && req.start, state == MD_MUL)
  `ASSERT_NXT(a_done_after_last, clk, rst, state == MD_DIV && count == '0, stat.done)
  `ASSERT_IMP(a_rem_below_div, clk, rst, state == MD_DIV, rem < d_r)

endmodule

`default_nettype wire

// File: rtl/core/ray_box_face_intersect.sv
// top level: ray against a configured axis-aligned cube, outward faces tested z, y, x
// a tested face runs two multiply-divides on the shared bit-serial divider
// a new ray is taken only in idle, once the previous result is loaded into the output register
// reset: synchronous, clears sequencer, divider and output valid; center 0, edge 1.0
`default_nettype none

`include "assert_macros.svh"

module ray_box_face_intersect (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rbfi_pkg::ADDR_W-1:0]         paddr,
  input  logic [rbfi_pkg::DATA_W-1:0]         pwdata,
  output logic [rbfi_pkg::DATA_W-1:0]         prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [rbfi_pkg::COORD_W-1:0] origin_x,
  input  logic signed [rbfi_pkg::COORD_W-1:0] origin_y,
  input  logic signed [rbfi_pkg::COORD_W-1:0] origin_z,
  input  logic signed [rbfi_pkg::DIR_W-1:0]   dir_x,
  input  logic signed [rbfi_pkg::DIR_W-1:0]   dir_y,
  input  logic signed [rbfi_pkg::DIR_W-1:0]   dir_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                hit,
  output logic signed [rbfi_pkg::COORD_W-1:0] point_x,
  output logic signed [rbfi_pkg::COORD_W-1:0] point_y,
  output logic signed [rbfi_pkg::COORD_W-1:0] point_z,
  output logic [1:0]                          face_axis,
  output logic                                face_negative
);
  import rbfi_pkg::*;

  function automatic logic [DIR_W-1:0] dir_mag(input logic signed [DIR_W-1:0] d);
    dir_mag = d[DIR_W-1] ? DIR_W'(-d) : d;
  endfunction

  function automatic logic in_slab(input logic signed [PT_W-1:0] p,
                                   input logic signed [CALC_W-1:0] c,
                                   input logic signed [CALC_W-1:0] e);
    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] lim;
    diff    = DIFF_W'(p) - DIFF_W'(c);
    lim     = DIFF_W'(e);
    in_slab = (diff <= lim) && (diff >= -lim);
  endfunction

  // configuration registers
  logic signed [COORD_W-1:0] center_x;
  logic signed [COORD_W-1:0] center_y;
  logic signed [COORD_W-1:0] center_z;
  logic [EDGE_W-1:0]         box_edge;
  logic                      cfg_wr;
  reg_idx_t                  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_t'(paddr[REG_SHIFT+1:REG_SHIFT]);

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      center_z <= '0;
      box_edge <= EDGE_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_CENTER_X: center_x <= pwdata[COORD_W-1:0];
        REG_CENTER_Y: center_y <= pwdata[COORD_W-1:0];
        REG_CENTER_Z: center_z <= pwdata[COORD_W-1:0];
        REG_EDGE:     box_edge <= pwdata[EDGE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_CENTER_X: prdata = DATA_W'($unsigned(center_x));
      REG_CENTER_Y: prdata = DATA_W'($unsigned(center_y));
      REG_CENTER_Z: prdata = DATA_W'($unsigned(center_z));
      REG_EDGE:     prdata = DATA_W'(box_edge);
      default:      prdata = '0;
    endcase
  end

  // doubled-scale cube
  logic signed [CALC_W-1:0] c2x;
  logic signed [CALC_W-1:0] c2y;
  logic signed [CALC_W-1:0] c2z;
  logic signed [CALC_W-1:0] e2;

  assign c2x = CALC_W'($signed({center_x, 1'b0}));
  assign c2y = CALC_W'($signed({center_y, 1'b0}));
  assign c2z = CALC_W'($signed({center_z, 1'b0}));
  assign e2  = CALC_W'({1'b0, box_edge});

  // ray and working registers
  rbfi_state_t              state;
  rbfi_state_t              state_next;
  logic signed [O2_W-1:0]   o2_x;
  logic signed [O2_W-1:0]   o2_y;
  logic signed [O2_W-1:0]   o2_z;
  logic signed [DIR_W-1:0]  d_x;
  logic signed [DIR_W-1:0]  d_y;
  logic signed [DIR_W-1:0]  d_z;
  logic [2:0]               below;
  logic [2:0]               above;
  logic [1:0]               ax;
  logic [1:0]               bx;
  logic signed [PT_W-1:0]   pt_x;
  logic signed [PT_W-1:0]   pt_y;
  logic signed [PT_W-1:0]   pt_z;
  logic [NUM_MW-1:0]        num_mag;
  logic                     num_neg;
  logic                     found;

  // selected operands
  logic signed [O2_W-1:0]   o2_a;
  logic signed [O2_W-1:0]   o2_b;
  logic signed [DIR_W-1:0]  d_a;
  logic signed [DIR_W-1:0]  d_b;
  logic signed [CALC_W-1:0] c2_a;
  logic signed [PT_W-1:0]   pt_a;
  logic signed [CALC_W-1:0] p2_a;
  logic signed [CALC_W-1:0] num;
  logic signed [PT_W-1:0]   q_ext;
  logic signed [PT_W-1:0]   pt_new;
  logic                     approach;
  logic                     neg;
  logic                     last_b;
  logic [1:0]               first_b;
  logic [1:0]               step_b;
  logic                     all_in;
  logic                     out_load;
  logic                     miss_zero;

  md_req_t                  md_req;
  md_stat_t                 md_stat;
  logic [PROD_W-1:0]        md_q;

  always_comb begin
    case (ax)
      AXIS_X: begin
        o2_a = o2_x; d_a = d_x; c2_a = c2x; pt_a = pt_x;
      end
      AXIS_Y: begin
        o2_a = o2_y; d_a = d_y; c2_a = c2y; pt_a = pt_y;
      end
      default: begin
        o2_a = o2_z; d_a = d_z; c2_a = c2z; pt_a = pt_z;
      end
    endcase
    case (bx)
      AXIS_X: begin
        o2_b = o2_x; d_b = d_x;
      end
      AXIS_Y: begin
        o2_b = o2_y; d_b = d_y;
      end
      default: begin
        o2_b = o2_z; d_b = d_z;
      end
    endcase
  end

  assign approach = above[ax] ? d_a[DIR_W-1]
                  : (below[ax] ? (!d_a[DIR_W-1] && (|d_a)) : 1'b0);
  assign p2_a     = c2_a + (above[ax] ? e2 : -e2);
  assign num      = CALC_W'(pt_a) - CALC_W'(o2_a);
  assign neg      = num_neg ^ d_b[DIR_W-1] ^ d_a[DIR_W-1];
  assign q_ext    = $signed(PT_W'(md_q));
  assign pt_new   = neg ? PT_W'(o2_b) - q_ext : PT_W'(o2_b) + q_ext;
  assign last_b   = (bx == AXIS_Z) || ((bx == AXIS_Y) && (ax == AXIS_Z));
  assign first_b  = (ax == AXIS_X) ? AXIS_Y : AXIS_X;
  assign step_b   = ((bx == AXIS_X) && (ax != AXIS_Y)) ? AXIS_Y : AXIS_Z;
  assign all_in   = in_slab(pt_x, c2x, e2) && in_slab(pt_y, c2y, e2)
                    && in_slab(pt_z, c2z, e2);

  assign in_stall = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    md_req.start = 1'b0;
    md_req.a     = num_mag;
    md_req.b     = dir_mag(d_b);
    md_req.d     = dir_mag(d_a);
    out_load     = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_CLASS;
      end
      S_CLASS: state_next = S_FACE;
      S_FACE: begin
        if (approach) begin
          state_next = S_NUM;
        end else if (ax == AXIS_X) begin
          state_next = S_DONE;
        end
      end
      S_NUM: state_next = S_MD_START;
      S_MD_START: begin
        md_req.start = 1'b1;
        state_next   = S_MD_WAIT;
      end
      S_MD_WAIT: begin
        if (md_stat.done) state_next = last_b ? S_CHECK : S_MD_START;
      end
      S_CHECK: begin
        state_next = (all_in || (ax == AXIS_X)) ? S_DONE : S_FACE;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          o2_x <= {origin_x, 1'b0};
          o2_y <= {origin_y, 1'b0};
          o2_z <= {origin_z, 1'b0};
          d_x  <= dir_x;
          d_y  <= dir_y;
          d_z  <= dir_z;
        end
      end
      S_CLASS: begin
        below[0] <= CALC_W'(o2_x) < c2x - e2;
        below[1] <= CALC_W'(o2_y) < c2y - e2;
        below[2] <= CALC_W'(o2_z) < c2z - e2;
        above[0] <= CALC_W'(o2_x) > c2x + e2;
        above[1] <= CALC_W'(o2_y) > c2y + e2;
        above[2] <= CALC_W'(o2_z) > c2z + e2;
        ax       <= AXIS_Z;
        found    <= 1'b0;
      end
      S_FACE: begin
        if (approach) begin
          case (ax)
            AXIS_X:  pt_x <= PT_W'(p2_a);
            AXIS_Y:  pt_y <= PT_W'(p2_a);
            default: pt_z <= PT_W'(p2_a);
          endcase
          bx <= first_b;
        end else if (ax != AXIS_X) begin
          ax <= ax - 2'd1;
        end
      end
      S_NUM: begin
        num_mag <= num[CALC_W-1] ? NUM_MW'(-num) : NUM_MW'(num);
        num_neg <= num[CALC_W-1];
      end
      S_MD_WAIT: begin
        if (md_stat.done) begin
          case (bx)
            AXIS_X:  pt_x <= pt_new;
            AXIS_Y:  pt_y <= pt_new;
            default: pt_z <= pt_new;
          endcase
          if (!last_b) bx <= step_b;
        end
      end
      S_CHECK: begin
        found <= all_in;
        if (!all_in && (ax != AXIS_X)) ax <= ax - 2'd1;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      hit           <= found;
      point_x       <= found ? half_sat(pt_x) : '0;
      point_y       <= found ? half_sat(pt_y) : '0;
      point_z       <= found ? half_sat(pt_z) : '0;
      face_axis     <= found ? ax : AXIS_X;
      face_negative <= found & below[ax];
    end
  end

  rbfi_muldiv u_muldiv (
    .clk  (clk),
    .rst  (rst),
    .req  (md_req),
    .stat (md_stat),
    .q    (md_q)
  );

  assign miss_zero = (point_x == '0) && (point_y == '0) && (point_z == '0)
                     && (face_axis == AXIS_X) && !face_negative;

  `ASSERT_NXT(a_accept_to_class, clk, rst, in_valid && !in_stall, state == S_CLASS)
  `ASSERT_IMP(a_start_when_free, clk, rst, md_req.start, !md_stat.busy)
  `ASSERT_IMP(a_done_while_wait, clk, rst, md_stat.done, state == S_MD_WAIT)
  `ASSERT_IMP(a_miss_reads_zero, clk, rst, out_valid && !hit, miss_zero)

endmodule

`default_nettype wire
